/* rtl/dinic_max_flow_engine_defines.svh */
// Assertion macros shared by the flow engine RTL.
`ifndef DINIC_MAX_FLOW_ENGINE_DEFINES_SVH
`define DINIC_MAX_FLOW_ENGINE_DEFINES_SVH
// A condition that must hold at every clock edge out of reset.
`define DMF_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// A consequence that must hold in the same cycle as its antecedent.
`define DMF_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`endif

/* rtl/dmf_pkg.sv */
// Shared codes and transaction types of the max-flow engine.
`timescale 1ns / 1ps
`default_nettype none
package dmf_pkg;
   localparam int VALUE_WIDTH = 48;

   localparam logic [2:0] OP_ADD_EDGE    = 3'd0;
   localparam logic [2:0] OP_SOLVE       = 3'd1;
   localparam logic [2:0] OP_READ_FLOW   = 3'd2;
   localparam logic [2:0] OP_CLEAR_FLOWS = 3'd3;
   localparam logic [2:0] OP_CLEAR_GRAPH = 3'd4;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_SELF_LOOP = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_RANGE     = 2'd3;

   localparam logic signed [63:0] PUSH_LIMIT = 64'sd1000000000000000000;

   typedef struct packed {
      logic [2:0]  op;
      logic [7:0]  src_vertex;
      logic [7:0]  dst_vertex;
      logic [31:0] capacity;
      logic        bidirectional;
      logic [11:0] edge_index;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] value;
      logic [1:0]                    status;
   } rsp_type;
endpackage
`default_nettype wire

/* rtl/dinic_max_flow_engine.sv */
// Dinic maximum-flow engine: graph store, level pass and blocking-flow search.
// A user should know first: every item returns exactly one result transaction.
// Add edge writes the forward arc and then the reverse arc; clear flows
// sweeps every stored arc and clear graph every vertex list head. After reset
// the engine sweeps the vertex list heads before it accepts the first item;
// configuration writes are taken throughout. A solve repeats level passes;
// each pass resets every vertex level, dequeues vertices and scans their
// arcs, loads the current-arc pointers, then tries arcs, retreats and pushes
// flow along each augmenting path. Every array lives in a single-write,
// single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
`include "dinic_max_flow_engine_defines.svh"
module dinic_max_flow_engine #(
   parameter int MAX_VERTICES = 256,
   parameter int MAX_ARCS     = 4096,
   parameter int CAP_WIDTH    = 32,
   parameter int FLOW_WIDTH   = 48
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire dmf_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output dmf_pkg::rsp_type      rsp_data,
   input  wire logic             csr_write_enable,
   input  wire logic [8:0]       csr_write_data
);
   import dmf_pkg::*;

   localparam int VW  = $clog2(MAX_VERTICES);
   localparam int AW  = $clog2(MAX_ARCS);
   localparam int CW  = AW + 1;
   localparam int LW  = VW + 1;
   localparam int NVW = (VW + 1 > 9) ? VW + 1 : 9;
   localparam int IXW = (CW > 12) ? CW : 12;
   localparam int SWW = (LW > CW) ? LW : CW;
   localparam int RW  = 66;
   localparam logic [CW-1:0] NO_ARC    = CW'(MAX_ARCS);
   localparam logic [LW-1:0] UNREACHED = '1;
   localparam logic [63:0]   FLOW_LIMIT = 64'((65'd1 << (FLOW_WIDTH - 1)) - 65'd1);

   typedef struct packed {
      logic [CW-1:0] first;
      logic [AW-1:0] last;
   } vtx_rec_type;

   typedef struct packed {
      logic [VW-1:0]        head;
      logic [CAP_WIDTH-1:0] cap;
   } arc_rec_type;

   typedef struct packed {
      logic [AW-1:0]      arc;
      logic signed [63:0] bn;
   } path_rec_type;

   typedef enum logic [27:0] {
      ST_CLEAR    = 28'h000_0001,
      ST_IDLE     = 28'h000_0002,
      ST_RESP     = 28'h000_0004,
      ST_ADD_S    = 28'h000_0008,
      ST_ADD_D    = 28'h000_0010,
      ST_READ     = 28'h000_0020,
      ST_FLOWCLR  = 28'h000_0040,
      ST_LP_INIT  = 28'h000_0080,
      ST_LP_SEED  = 28'h000_0100,
      ST_LP_DEQ   = 28'h000_0200,
      ST_LP_U     = 28'h000_0400,
      ST_LP_UF    = 28'h000_0800,
      ST_LP_A     = 28'h000_1000,
      ST_LP_V     = 28'h000_2000,
      ST_LP_CHK   = 28'h000_4000,
      ST_COPY     = 28'h000_8000,
      ST_AUG_U    = 28'h001_0000,
      ST_AUG_CUR  = 28'h002_0000,
      ST_AUG_SCAN = 28'h004_0000,
      ST_AUG_ARC  = 28'h008_0000,
      ST_AUG_LV   = 28'h010_0000,
      ST_AUG_RET  = 28'h020_0000,
      ST_AUG_RET2 = 28'h040_0000,
      ST_AUG_RET3 = 28'h080_0000,
      ST_PU_RD    = 28'h100_0000,
      ST_PU_A     = 28'h200_0000,
      ST_PU_WA    = 28'h400_0000,
      ST_PU_WB    = 28'h800_0000
   } state_type;

   state_type          state_ff, state_in;
   logic [8:0]         vcount_ff, vcount_in;
   req_type            req_q_ff, req_q_in;
   logic [CW-1:0]      arc_count_ff, arc_count_in;
   logic [SWW-1:0]     swp_ff, swp_in;
   logic               clr_resp_ff, clr_resp_in;
   logic [VW-1:0]      u_ff, u_in;
   logic [VW-1:0]      v_ff, v_in;
   logic [CW-1:0]      a_ff, a_in;
   logic [CW-1:0]      nxt_ff, nxt_in;
   logic [AW-1:0]      last_ff, last_in;
   logic [LW-1:0]      ulvl_ff, ulvl_in;
   logic signed [RW-1:0] resid_ff, resid_in;
   logic [LW-1:0]      head_ff, head_in;
   logic [LW-1:0]      tail_ff, tail_in;
   logic [LW-1:0]      depth_ff, depth_in;
   logic signed [63:0] bn_ff, bn_in;
   logic [63:0]        pushed_ff, pushed_in;
   logic [63:0]        total_ff, total_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;
   rsp_type            hold_ff, hold_in;

   // RAM ports.
   logic               vtx_we, arc_we, next_we, flow_we, lvl_we, cur_we, q_we, path_we;
   logic [VW-1:0]      vtx_waddr, vtx_raddr, lvl_waddr, lvl_raddr;
   logic [VW-1:0]      cur_waddr, cur_raddr, q_waddr, q_raddr, path_waddr, path_raddr;
   logic [AW-1:0]      arc_waddr, arc_raddr, next_waddr, next_raddr, flow_waddr, flow_raddr;
   vtx_rec_type        vtx_wdata, vtx_rdata;
   arc_rec_type        arc_wdata, arc_rdata;
   logic [AW-1:0]      next_wdata, next_rdata;
   logic [FLOW_WIDTH-1:0] flow_wdata, flow_rdata;
   logic [LW-1:0]      lvl_wdata, lvl_rdata;
   logic [CW-1:0]      cur_wdata, cur_rdata;
   logic [VW-1:0]      q_wdata, q_rdata;
   path_rec_type       path_wdata, path_rdata;

   logic               fin;
   rsp_type            fin_data;
   logic [NVW-1:0]     vc_ext, nv_eff;
   logic               sv_bad, dv_bad, idx_bad, store_full;
   logic [VW-1:0]      src_v, dst_v;
   logic [CAP_WIDTH-1:0] cap_eff;
   logic [AW-1:0]      a_even, a_odd;
   logic signed [RW-1:0] resid_now;
   logic               resid_pos;
   logic [CW-1:0]      next_or_end;

   assign vc_ext = NVW'(vcount_ff);
   assign nv_eff = (vc_ext < NVW'(2)) ? NVW'(2) :
                   (vc_ext > NVW'(MAX_VERTICES)) ? NVW'(MAX_VERTICES) : vc_ext;
   assign sv_bad = NVW'(req_data.src_vertex) >= nv_eff;
   assign dv_bad = NVW'(req_data.dst_vertex) >= nv_eff;
   assign idx_bad = IXW'(req_data.edge_index) >= IXW'(arc_count_ff);
   assign store_full = (arc_count_ff + CW'(2)) > CW'(MAX_ARCS);
   assign src_v = VW'(req_q_ff.src_vertex);
   assign dst_v = VW'(req_q_ff.dst_vertex);
   assign cap_eff = CAP_WIDTH'(64'(req_q_ff.capacity));
   assign a_even = arc_count_ff[AW-1:0];
   assign a_odd = {arc_count_ff[AW-1:1], 1'b1};
   assign resid_now = $signed({{(RW - CAP_WIDTH){1'b0}}, arc_rdata.cap})
                    - $signed({{(RW - FLOW_WIDTH){flow_rdata[FLOW_WIDTH-1]}}, flow_rdata});
   assign resid_pos = !resid_now[RW-1] && (resid_now != '0);
   // The last arc of a vertex list has no valid next link; its end is found by
   // comparing against the list tail instead.
   assign next_or_end = (a_ff[AW-1:0] == last_ff) ? NO_ARC : CW'(next_rdata);

   always_comb begin
      state_in = state_ff;
      req_q_in = req_q_ff;
      arc_count_in = arc_count_ff;
      swp_in = swp_ff;
      clr_resp_in = clr_resp_ff;
      u_in = u_ff;
      v_in = v_ff;
      a_in = a_ff;
      nxt_in = nxt_ff;
      last_in = last_ff;
      ulvl_in = ulvl_ff;
      resid_in = resid_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      depth_in = depth_ff;
      bn_in = bn_ff;
      pushed_in = pushed_ff;
      total_in = total_ff;
      hold_in = hold_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in = rsp_data_ff;
      req_ready = (state_ff == ST_IDLE);
      fin = 1'b0;
      fin_data.value = '0;
      fin_data.status = ST_OK;

      vtx_we = 1'b0;  vtx_waddr = '0;  vtx_wdata = '0;  vtx_raddr = '0;
      arc_we = 1'b0;  arc_waddr = '0;  arc_wdata = '0;  arc_raddr = '0;
      next_we = 1'b0; next_waddr = '0; next_wdata = '0; next_raddr = '0;
      flow_we = 1'b0; flow_waddr = '0; flow_wdata = '0; flow_raddr = '0;
      lvl_we = 1'b0;  lvl_waddr = '0;  lvl_wdata = '0;  lvl_raddr = '0;
      cur_we = 1'b0;  cur_waddr = '0;  cur_wdata = '0;  cur_raddr = '0;
      q_we = 1'b0;    q_waddr = '0;    q_wdata = '0;    q_raddr = '0;
      path_we = 1'b0; path_waddr = '0; path_wdata = '0; path_raddr = '0;

      case (state_ff)
         ST_CLEAR: begin
            vtx_we = 1'b1;
            vtx_waddr = swp_ff[VW-1:0];
            vtx_wdata.first = NO_ARC;
            swp_in = swp_ff + SWW'(1);
            if (swp_ff == SWW'(MAX_VERTICES - 1)) begin
               if (clr_resp_ff) begin
                  fin = 1'b1;
               end else begin
                  state_in = ST_IDLE;
               end
               clr_resp_in = 1'b0;
            end
         end
         ST_IDLE: begin
            vtx_raddr = VW'(req_data.src_vertex);
            flow_raddr = AW'(req_data.edge_index);
            if (req_valid) begin
               req_q_in = req_data;
               case (req_data.op)
                  OP_ADD_EDGE: begin
                     if (sv_bad || dv_bad) begin
                        fin = 1'b1;
                        fin_data.status = ST_RANGE;
                     end else if (req_data.src_vertex == req_data.dst_vertex) begin
                        fin = 1'b1;
                        fin_data.status = ST_SELF_LOOP;
                     end else if (store_full) begin
                        fin = 1'b1;
                        fin_data.status = ST_FULL;
                     end else begin
                        state_in = ST_ADD_S;
                     end
                  end
                  OP_SOLVE: begin
                     if (sv_bad || dv_bad) begin
                        fin = 1'b1;
                        fin_data.status = ST_RANGE;
                     end else if (req_data.src_vertex == req_data.dst_vertex) begin
                        fin = 1'b1;
                        fin_data.status = ST_SELF_LOOP;
                     end else begin
                        total_in = '0;
                        swp_in = '0;
                        state_in = ST_LP_INIT;
                     end
                  end
                  OP_READ_FLOW: begin
                     if (idx_bad) begin
                        fin = 1'b1;
                        fin_data.status = ST_RANGE;
                     end else begin
                        state_in = ST_READ;
                     end
                  end
                  OP_CLEAR_FLOWS: begin
                     if (arc_count_ff == '0) begin
                        fin = 1'b1;
                     end else begin
                        swp_in = '0;
                        state_in = ST_FLOWCLR;
                     end
                  end
                  OP_CLEAR_GRAPH: begin
                     arc_count_in = '0;
                     swp_in = '0;
                     clr_resp_in = 1'b1;
                     state_in = ST_CLEAR;
                  end
                  default: begin
                     fin = 1'b1;
                  end
               endcase
            end
         end
         ST_RESP: begin
            fin = 1'b1;
            fin_data = hold_ff;
         end
         ST_ADD_S: begin
            arc_we = 1'b1;
            arc_waddr = a_even;
            arc_wdata.head = dst_v;
            arc_wdata.cap = cap_eff;
            flow_we = 1'b1;
            flow_waddr = a_even;
            if (vtx_rdata.first != NO_ARC) begin
               next_we = 1'b1;
               next_waddr = vtx_rdata.last;
               next_wdata = a_even;
            end
            vtx_we = 1'b1;
            vtx_waddr = src_v;
            vtx_wdata.first = (vtx_rdata.first == NO_ARC) ? CW'(a_even) : vtx_rdata.first;
            vtx_wdata.last = a_even;
            vtx_raddr = dst_v;
            state_in = ST_ADD_D;
         end
         ST_ADD_D: begin
            arc_we = 1'b1;
            arc_waddr = a_odd;
            arc_wdata.head = src_v;
            arc_wdata.cap = req_q_ff.bidirectional ? cap_eff : '0;
            flow_we = 1'b1;
            flow_waddr = a_odd;
            if (vtx_rdata.first != NO_ARC) begin
               next_we = 1'b1;
               next_waddr = vtx_rdata.last;
               next_wdata = a_odd;
            end
            vtx_we = 1'b1;
            vtx_waddr = dst_v;
            vtx_wdata.first = (vtx_rdata.first == NO_ARC) ? CW'(a_odd) : vtx_rdata.first;
            vtx_wdata.last = a_odd;
            arc_count_in = arc_count_ff + CW'(2);
            fin = 1'b1;
            fin_data.value = VALUE_WIDTH'(arc_count_ff);
         end
         ST_READ: begin
            fin = 1'b1;
            fin_data.value = VALUE_WIDTH'(64'(flow_rdata));
         end
         ST_FLOWCLR: begin
            flow_we = 1'b1;
            flow_waddr = swp_ff[AW-1:0];
            swp_in = swp_ff + SWW'(1);
            if (SWW'(arc_count_ff) == swp_ff + SWW'(1)) begin
               fin = 1'b1;
            end
         end
         ST_LP_INIT: begin
            lvl_we = 1'b1;
            lvl_waddr = swp_ff[VW-1:0];
            lvl_wdata = UNREACHED;
            swp_in = swp_ff + SWW'(1);
            if (swp_ff == SWW'(MAX_VERTICES - 1)) begin
               state_in = ST_LP_SEED;
            end
         end
         ST_LP_SEED: begin
            lvl_we = 1'b1;
            lvl_waddr = src_v;
            q_we = 1'b1;
            q_wdata = src_v;
            head_in = '0;
            tail_in = LW'(1);
            state_in = ST_LP_DEQ;
         end
         ST_LP_DEQ: begin
            if (head_ff < tail_ff) begin
               q_raddr = head_ff[VW-1:0];
               head_in = head_ff + LW'(1);
               state_in = ST_LP_U;
            end else begin
               lvl_raddr = dst_v;
               state_in = ST_LP_CHK;
            end
         end
         ST_LP_U: begin
            u_in = q_rdata;
            lvl_raddr = q_rdata;
            vtx_raddr = q_rdata;
            // Dequeuing the sink ends the pass; the level read then checks it.
            state_in = (q_rdata == dst_v) ? ST_LP_CHK : ST_LP_UF;
         end
         ST_LP_UF: begin
            ulvl_in = lvl_rdata;
            last_in = vtx_rdata.last;
            a_in = vtx_rdata.first;
            if (vtx_rdata.first == NO_ARC) begin
               state_in = ST_LP_DEQ;
            end else begin
               arc_raddr = vtx_rdata.first[AW-1:0];
               flow_raddr = vtx_rdata.first[AW-1:0];
               next_raddr = vtx_rdata.first[AW-1:0];
               state_in = ST_LP_A;
            end
         end
         ST_LP_A: begin
            v_in = arc_rdata.head;
            resid_in = resid_now;
            nxt_in = next_or_end;
            lvl_raddr = arc_rdata.head;
            state_in = ST_LP_V;
         end
         ST_LP_V: begin
            if (!resid_ff[RW-1] && (resid_ff != '0) && (lvl_rdata == UNREACHED) &&
                (tail_ff < LW'(MAX_VERTICES))) begin
               lvl_we = 1'b1;
               lvl_waddr = v_ff;
               lvl_wdata = ulvl_ff + LW'(1);
               q_we = 1'b1;
               q_waddr = tail_ff[VW-1:0];
               q_wdata = v_ff;
               tail_in = tail_ff + LW'(1);
            end
            a_in = nxt_ff;
            if (nxt_ff == NO_ARC) begin
               state_in = ST_LP_DEQ;
            end else begin
               arc_raddr = nxt_ff[AW-1:0];
               flow_raddr = nxt_ff[AW-1:0];
               next_raddr = nxt_ff[AW-1:0];
               state_in = ST_LP_A;
            end
         end
         ST_LP_CHK: begin
            if (lvl_rdata == UNREACHED) begin
               fin = 1'b1;
               fin_data.value = VALUE_WIDTH'(total_ff);
            end else begin
               swp_in = '0;
               state_in = ST_COPY;
            end
         end
         ST_COPY: begin
            // Read of entry i and write of entry i - 1 happen in the same cycle.
            vtx_raddr = swp_ff[VW-1:0];
            if (swp_ff != '0) begin
               cur_we = 1'b1;
               cur_waddr = VW'(swp_ff - SWW'(1));
               cur_wdata = vtx_rdata.first;
            end
            swp_in = swp_ff + SWW'(1);
            if (swp_ff == SWW'(MAX_VERTICES)) begin
               u_in = src_v;
               depth_in = '0;
               bn_in = PUSH_LIMIT;
               state_in = ST_AUG_U;
            end
         end
         ST_AUG_U: begin
            if (u_ff == dst_v) begin
               pushed_in = 64'(bn_ff);
               total_in = (64'(bn_ff) > FLOW_LIMIT - total_ff) ? FLOW_LIMIT
                                                                : total_ff + 64'(bn_ff);
               state_in = ST_PU_RD;
            end else begin
               cur_raddr = u_ff;
               lvl_raddr = u_ff;
               vtx_raddr = u_ff;
               state_in = ST_AUG_CUR;
            end
         end
         ST_AUG_CUR: begin
            a_in = cur_rdata;
            ulvl_in = lvl_rdata;
            last_in = vtx_rdata.last;
            state_in = ST_AUG_SCAN;
         end
         ST_AUG_SCAN: begin
            if (a_ff == NO_ARC) begin
               cur_we = 1'b1;
               cur_waddr = u_ff;
               cur_wdata = NO_ARC;
               if (depth_ff == '0) begin
                  swp_in = '0;
                  state_in = ST_LP_INIT;
               end else begin
                  depth_in = depth_ff - LW'(1);
                  path_raddr = VW'(depth_ff - LW'(1));
                  state_in = ST_AUG_RET;
               end
            end else begin
               arc_raddr = a_ff[AW-1:0];
               flow_raddr = a_ff[AW-1:0];
               next_raddr = a_ff[AW-1:0];
               state_in = ST_AUG_ARC;
            end
         end
         ST_AUG_ARC: begin
            v_in = arc_rdata.head;
            resid_in = resid_now;
            nxt_in = next_or_end;
            lvl_raddr = arc_rdata.head;
            state_in = ST_AUG_LV;
         end
         ST_AUG_LV: begin
            if ((lvl_rdata == ulvl_ff + LW'(1)) && !resid_ff[RW-1] && (resid_ff != '0)) begin
               cur_we = 1'b1;
               cur_waddr = u_ff;
               cur_wdata = a_ff;
               if (depth_ff < LW'(MAX_VERTICES)) begin
                  path_we = 1'b1;
                  path_waddr = VW'(depth_ff);
                  path_wdata.arc = a_ff[AW-1:0];
                  path_wdata.bn = bn_ff;
                  if (resid_ff < RW'(bn_ff)) begin
                     bn_in = resid_ff[63:0];
                  end
                  depth_in = depth_ff + LW'(1);
                  u_in = v_ff;
                  state_in = ST_AUG_U;
               end else begin
                  depth_in = depth_ff - LW'(1);
                  path_raddr = VW'(depth_ff - LW'(1));
                  state_in = ST_AUG_RET;
               end
            end else begin
               a_in = nxt_ff;
               state_in = ST_AUG_SCAN;
            end
         end
         ST_AUG_RET: begin
            a_in = CW'(path_rdata.arc);
            bn_in = path_rdata.bn;
            arc_raddr = {path_rdata.arc[AW-1:1], ~path_rdata.arc[0]};
            next_raddr = path_rdata.arc;
            state_in = ST_AUG_RET2;
         end
         ST_AUG_RET2: begin
            u_in = arc_rdata.head;
            nxt_in = CW'(next_rdata);
            vtx_raddr = arc_rdata.head;
            state_in = ST_AUG_RET3;
         end
         ST_AUG_RET3: begin
            // The vertex left behind steps its current arc past the dead one.
            cur_we = 1'b1;
            cur_waddr = u_ff;
            cur_wdata = (a_ff[AW-1:0] == vtx_rdata.last) ? NO_ARC : nxt_ff;
            state_in = ST_AUG_U;
         end
         ST_PU_RD: begin
            depth_in = depth_ff - LW'(1);
            path_raddr = VW'(depth_ff - LW'(1));
            state_in = ST_PU_A;
         end
         ST_PU_A: begin
            a_in = CW'(path_rdata.arc);
            flow_raddr = path_rdata.arc;
            state_in = ST_PU_WA;
         end
         ST_PU_WA: begin
            flow_we = 1'b1;
            flow_waddr = a_ff[AW-1:0];
            flow_wdata = FLOW_WIDTH'(64'($signed(flow_rdata)) + pushed_ff);
            flow_raddr = {a_ff[AW-1:1], ~a_ff[0]};
            state_in = ST_PU_WB;
         end
         ST_PU_WB: begin
            flow_we = 1'b1;
            flow_waddr = {a_ff[AW-1:1], ~a_ff[0]};
            flow_wdata = FLOW_WIDTH'(64'($signed(flow_rdata)) - pushed_ff);
            if (depth_ff == '0) begin
               u_in = src_v;
               bn_in = PUSH_LIMIT;
               state_in = ST_AUG_U;
            end else begin
               state_in = ST_PU_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // The result goes straight to the output register when it is free.
      if (fin) begin
         if (!rsp_valid_ff || rsp_ready) begin
            rsp_valid_in = 1'b1;
            rsp_data_in = fin_data;
            state_in = ST_IDLE;
         end else begin
            hold_in = fin_data;
            state_in = ST_RESP;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         vcount_ff <= 9'd256;
         arc_count_ff <= '0;
         swp_ff <= '0;
         clr_resp_ff <= 1'b0;
         head_ff <= '0;
         tail_ff <= '0;
         depth_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         vcount_ff <= csr_write_enable ? csr_write_data : vcount_ff;
         arc_count_ff <= arc_count_in;
         swp_ff <= swp_in;
         clr_resp_ff <= clr_resp_in;
         head_ff <= head_in;
         tail_ff <= tail_in;
         depth_ff <= depth_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_q_ff <= req_q_in;
      u_ff <= u_in;
      v_ff <= v_in;
      a_ff <= a_in;
      nxt_ff <= nxt_in;
      last_ff <= last_in;
      ulvl_ff <= ulvl_in;
      resid_ff <= resid_in;
      bn_ff <= bn_in;
      pushed_ff <= pushed_in;
      total_ff <= total_in;
      rsp_data_ff <= rsp_data_in;
      hold_ff <= hold_in;
   end

   assign vcount_in = vcount_ff;
   assign rsp_valid = rsp_valid_ff && (vcount_in == vcount_ff);
   assign rsp_data = rsp_data_ff;

   dmf_ram #(.WIDTH($bits(vtx_rec_type)), .DEPTH(MAX_VERTICES)) u_vtx_ram (
      .clock(clock), .write_enable(vtx_we), .write_address(vtx_waddr),
      .write_data(vtx_wdata), .read_address(vtx_raddr), .read_data(vtx_rdata));
   dmf_ram #(.WIDTH($bits(arc_rec_type)), .DEPTH(MAX_ARCS)) u_arc_ram (
      .clock(clock), .write_enable(arc_we), .write_address(arc_waddr),
      .write_data(arc_wdata), .read_address(arc_raddr), .read_data(arc_rdata));
   dmf_ram #(.WIDTH(AW), .DEPTH(MAX_ARCS)) u_next_ram (
      .clock(clock), .write_enable(next_we), .write_address(next_waddr),
      .write_data(next_wdata), .read_address(next_raddr), .read_data(next_rdata));
   dmf_ram #(.WIDTH(FLOW_WIDTH), .DEPTH(MAX_ARCS)) u_flow_ram (
      .clock(clock), .write_enable(flow_we), .write_address(flow_waddr),
      .write_data(flow_wdata), .read_address(flow_raddr), .read_data(flow_rdata));
   dmf_ram #(.WIDTH(LW), .DEPTH(MAX_VERTICES)) u_lvl_ram (
      .clock(clock), .write_enable(lvl_we), .write_address(lvl_waddr),
      .write_data(lvl_wdata), .read_address(lvl_raddr), .read_data(lvl_rdata));
   dmf_ram #(.WIDTH(CW), .DEPTH(MAX_VERTICES)) u_cur_ram (
      .clock(clock), .write_enable(cur_we), .write_address(cur_waddr),
      .write_data(cur_wdata), .read_address(cur_raddr), .read_data(cur_rdata));
   dmf_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_q_ram (
      .clock(clock), .write_enable(q_we), .write_address(q_waddr),
      .write_data(q_wdata), .read_address(q_raddr), .read_data(q_rdata));
   dmf_ram #(.WIDTH($bits(path_rec_type)), .DEPTH(MAX_VERTICES)) u_path_ram (
      .clock(clock), .write_enable(path_we), .write_address(path_waddr),
      .write_data(path_wdata), .read_address(path_raddr), .read_data(path_rdata));

   `DMF_ASSERT_ALWAYS(a_arc_count_even, clock, reset,
      !arc_count_ff[0] && (arc_count_ff <= CW'(MAX_ARCS)), "arc count odd or beyond store")
   `DMF_ASSERT_ALWAYS(a_depth_bound, clock, reset,
      depth_ff <= LW'(MAX_VERTICES), "path depth beyond vertex count")
   `DMF_ASSERT_ALWAYS(a_queue_order, clock, reset,
      (tail_ff <= LW'(MAX_VERTICES)) && (head_ff <= tail_ff), "level queue pointers crossed")
   `DMF_ASSERT_IMPLY(a_resp_waits, clock, reset,
      state_ff == ST_RESP, rsp_valid_ff, "result held back with the output register empty")
endmodule
`default_nettype wire

/* rtl/dmf_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module dmf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     write_enable,
   input  wire logic [$clog2(DEPTH)-1:0] write_address,
   input  wire logic [WIDTH-1:0]         write_data,
   input  wire logic [$clog2(DEPTH)-1:0] read_address,
   output logic      [WIDTH-1:0]         read_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_address] <= write_data;
      end
      read_data_ff <= mem_ff[read_address];
   end

   assign read_data = read_data_ff;
endmodule
`default_nettype wire
